[rtl/assert_macros.svh]
// Assertion macros shared by the rank/select bit vector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RSB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rsb property violated");

// Check that a condition never holds outside reset.
`define RSB_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rsb forbidden condition seen");

`endif

[rtl/rsb_pkg.sv]
// Shared constants, codes and control structs of the rank/select bit vector.
package rsb_pkg;

  localparam int unsigned MaxWords  = 1024;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned IdxW      = 16;
  localparam int unsigned PrefixW   = 16;
  localparam int unsigned MemW      = PrefixW + WordBits;
  localparam int unsigned WordAddrW = $clog2(MaxWords);
  localparam int unsigned LoadW     = WordAddrW + 1;
  localparam int unsigned BitSelW   = $clog2(WordBits);
  localparam int unsigned PopW      = BitSelW + 1;
  localparam int unsigned ActW      = 3;

  localparam logic [WordBits-1:0] PopM1  = 32'h5555_5555;
  localparam logic [WordBits-1:0] PopM2  = 32'h3333_3333;
  localparam logic [WordBits-1:0] PopM4  = 32'h0F0F_0F0F;
  localparam logic [WordBits-1:0] PopM8  = 32'h00FF_00FF;
  localparam logic [WordBits-1:0] PopM16 = 32'h0000_FFFF;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_ACCESS = 3'd2,
    ACT_RANK   = 3'd3,
    ACT_SELECT = 3'd4
  } action_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic append;
    logic rd;
    logic ones;
    logic eval;
    logic mid;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exec_fin;
    logic exec_append;
    logic eval_more;
    logic search_go;
  } sts_t;

  function automatic logic [PopW-1:0] pop32(input logic [WordBits-1:0] v);
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
    logic [WordBits-1:0] c;
    logic [WordBits-1:0] d;
    logic [WordBits-1:0] e;
    a = (v & PopM1) + ((v >> 1) & PopM1);
    b = (a & PopM2) + ((a >> 2) & PopM2);
    c = (b & PopM4) + ((b >> 4) & PopM4);
    d = (c & PopM8) + ((c >> 8) & PopM8);
    e = (d & PopM16) + ((d >> 16) & PopM16);
    return e[PopW-1:0];
  endfunction

endpackage

[rtl/rsb_in_if.sv]
// Request channel carrying one action and its operands.
interface rsb_in_if;
  logic                         valid;
  logic                         ready;
  logic [rsb_pkg::ActW-1:0]     action;
  logic [rsb_pkg::WordBits-1:0] word_data;
  logic [rsb_pkg::IdxW-1:0]     bit_index;
  logic [rsb_pkg::IdxW-1:0]     target_count;
  logic                         bit_value;

  modport source (
    output valid, action, word_data, bit_index, target_count, bit_value,
    input  ready
  );
  modport sink (
    input  valid, action, word_data, bit_index, target_count, bit_value,
    output ready
  );
endinterface

[rtl/rsb_out_if.sv]
// Response channel carrying one answer and its status.
interface rsb_out_if;
  logic                     valid;
  logic                     ready;
  logic [rsb_pkg::IdxW-1:0] answer;
  logic                     status;

  modport source (
    output valid, answer, status,
    input  ready
  );
  modport sink (
    input  valid, answer, status,
    output ready
  );
endinterface

[rtl/rsb_ctrl.sv]
// Sequencing state machine of the rank/select bit vector.
`include "assert_macros.svh"

module rsb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rsb_pkg::sts_t sts_i,
  output rsb_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_EXEC = 8'b0000_0010,
    ST_APND = 8'b0000_0100,
    ST_RD   = 8'b0000_1000,
    ST_ONES = 8'b0001_0000,
    ST_EVAL = 8'b0010_0000,
    ST_MID  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fin_stall;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.exec_fin) begin
          state_d = ST_FIN;
        end else if (sts_i.exec_append) begin
          state_d = ST_APND;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_APND: begin
        cmd_o.append = 1'b1;
        state_d      = ST_FIN;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_ONES;
      end
      ST_ONES: begin
        cmd_o.ones = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.eval_more ? ST_MID : ST_FIN;
      end
      ST_MID: begin
        cmd_o.mid = 1'b1;
        state_d   = sts_i.search_go ? ST_RD : ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fin_stall   = (state_q == ST_FIN) && out_valid_q && !out_ready_i;

  `RSB_ASSERT(a_fin_holds, clk_i, rst_ni, fin_stall |=> (state_q == ST_FIN && out_valid_q))

endmodule

[rtl/rsb_dp.sv]
// Datapath of the rank/select bit vector: word store, prefix counts, search.
`include "assert_macros.svh"

module rsb_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rsb_pkg::cmd_t                cmd_i,
  output rsb_pkg::sts_t                sts_o,
  input  logic                         cfg_we_i,
  input  logic [rsb_pkg::IdxW-1:0]     cfg_wdata_i,
  input  logic [rsb_pkg::ActW-1:0]     action_i,
  input  logic [rsb_pkg::WordBits-1:0] word_data_i,
  input  logic [rsb_pkg::IdxW-1:0]     bit_index_i,
  input  logic [rsb_pkg::IdxW-1:0]     target_count_i,
  input  logic                         bit_value_i,
  output logic [rsb_pkg::IdxW-1:0]     answer_o,
  output logic                         status_o
);

  logic [rsb_pkg::MemW-1:0] mem_q [rsb_pkg::MaxWords];
  logic [rsb_pkg::MemW-1:0] rd_q;

  logic [rsb_pkg::IdxW-1:0]     bit_length_q;
  logic [rsb_pkg::LoadW-1:0]    loaded_q;
  logic [rsb_pkg::PrefixW-1:0]  total_q;
  logic                         phase_q;

  logic [rsb_pkg::ActW-1:0]     act_q;
  logic [rsb_pkg::WordBits-1:0] data_q;
  logic [rsb_pkg::IdxW-1:0]     idx_q;
  logic [rsb_pkg::IdxW-1:0]     cnt_q;
  logic                         b_q;
  logic [rsb_pkg::IdxW-1:0]     pos_q;
  logic [rsb_pkg::IdxW-1:0]     lp_q;
  logic [rsb_pkg::IdxW-1:0]     right_q;
  logic                         hit_q;
  logic                         bit_q;
  logic [rsb_pkg::PrefixW-1:0]  ones_q;
  logic [rsb_pkg::IdxW-1:0]     res_ans_q;
  logic                         res_sts_q;
  logic [rsb_pkg::IdxW-1:0]     out_ans_q;
  logic                         out_sts_q;

  logic                         early_err;
  logic                         full;
  logic [rsb_pkg::IdxW-1:0]     base;
  logic [rsb_pkg::IdxW-1:0]     diff;
  logic [rsb_pkg::WordBits-1:0] masked;
  logic [rsb_pkg::WordBits-1:0] rd_word;
  logic [rsb_pkg::PrefixW-1:0]  rd_pre;
  logic [rsb_pkg::BitSelW-1:0]  sel;
  logic [rsb_pkg::PrefixW-1:0]  ones_d;
  logic [rsb_pkg::IdxW-1:0]     rank;
  logic                         sel_fail;
  logic [rsb_pkg::IdxW:0]       mid_sum;
  logic [rsb_pkg::IdxW-1:0]     mid;
  logic                         probe_go;

  always_comb begin
    case (act_q)
      rsb_pkg::ACT_ACCESS: early_err = (idx_q >= bit_length_q);
      rsb_pkg::ACT_RANK:   early_err = (idx_q > bit_length_q);
      rsb_pkg::ACT_SELECT: early_err = (cnt_q == '0);
      default:             early_err = 1'b0;
    endcase
  end

  assign full = (loaded_q >= rsb_pkg::LoadW'(rsb_pkg::MaxWords));
  assign base = rsb_pkg::IdxW'({loaded_q[rsb_pkg::WordAddrW-1:0],
                                {rsb_pkg::BitSelW{1'b0}}});
  assign diff = bit_length_q - base;

  always_comb begin
    if (bit_length_q <= base) begin
      masked = '0;
    end else if (diff < rsb_pkg::IdxW'(rsb_pkg::WordBits)) begin
      masked = data_q & ~({rsb_pkg::WordBits{1'b1}} << diff[rsb_pkg::BitSelW-1:0]);
    end else begin
      masked = data_q;
    end
  end

  assign rd_word = rd_q[rsb_pkg::WordBits-1:0];
  assign rd_pre  = rd_q[rsb_pkg::MemW-1:rsb_pkg::WordBits];
  assign sel     = pos_q[rsb_pkg::BitSelW-1:0];
  assign ones_d  = hit_q
    ? rd_pre + rsb_pkg::PrefixW'(rsb_pkg::pop32(
        rd_word & ~({rsb_pkg::WordBits{1'b1}} << sel)))
    : total_q;

  always_comb begin
    if (b_q) begin
      rank = ones_q;
    end else if (ones_q <= pos_q) begin
      rank = pos_q - ones_q;
    end else begin
      rank = '0;
    end
  end

  assign sel_fail = !phase_q && (cnt_q > rank);
  assign mid_sum  = {1'b0, lp_q} + {1'b0, right_q} - 1'b1;
  assign mid      = mid_sum[rsb_pkg::IdxW:1];

  always_comb begin
    sts_o.exec_fin = 1'b0;
    case (act_q)
      rsb_pkg::ACT_APPEND: sts_o.exec_fin = full;
      rsb_pkg::ACT_ACCESS,
      rsb_pkg::ACT_RANK,
      rsb_pkg::ACT_SELECT: sts_o.exec_fin = early_err;
      default:             sts_o.exec_fin = 1'b1;
    endcase
    sts_o.exec_append = (act_q == rsb_pkg::ACT_APPEND) && !full;
    sts_o.eval_more   = (act_q == rsb_pkg::ACT_SELECT) && !sel_fail;
    sts_o.search_go   = (lp_q < right_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[loaded_q[rsb_pkg::WordAddrW-1:0]] <= {total_q, data_q};
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[pos_q[rsb_pkg::BitSelW +: rsb_pkg::WordAddrW]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_length_q <= '0;
      loaded_q     <= '0;
      total_q      <= '0;
      phase_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bit_length_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        phase_q <= 1'b0;
        if (act_q == rsb_pkg::ACT_CLEAR) begin
          loaded_q <= '0;
          total_q  <= '0;
        end
      end
      if (cmd_i.append) begin
        total_q  <= total_q + rsb_pkg::PrefixW'(rsb_pkg::pop32(data_q));
        loaded_q <= loaded_q + 1'b1;
      end
      if (cmd_i.eval && (act_q == rsb_pkg::ACT_SELECT) && !sel_fail) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      data_q <= word_data_i;
      idx_q  <= bit_index_i;
      cnt_q  <= target_count_i;
      b_q    <= bit_value_i;
    end
    if (cmd_i.exec) begin
      res_ans_q <= '0;
      res_sts_q <= early_err || ((act_q == rsb_pkg::ACT_APPEND) && full);
      pos_q     <= (act_q == rsb_pkg::ACT_SELECT) ? bit_length_q : idx_q;
      if (act_q == rsb_pkg::ACT_APPEND) begin
        data_q <= masked;
      end
    end
    if (cmd_i.rd) begin
      hit_q <= (pos_q[rsb_pkg::IdxW-1:rsb_pkg::BitSelW] < loaded_q);
    end
    if (cmd_i.ones) begin
      ones_q <= ones_d;
      bit_q  <= hit_q & rd_word[sel];
    end
    if (cmd_i.eval) begin
      case (act_q)
        rsb_pkg::ACT_ACCESS: res_ans_q <= rsb_pkg::IdxW'(bit_q);
        rsb_pkg::ACT_RANK:   res_ans_q <= rank;
        rsb_pkg::ACT_SELECT: begin
          if (!phase_q) begin
            if (sel_fail) begin
              res_sts_q <= 1'b1;
            end else begin
              lp_q    <= '0;
              right_q <= bit_length_q;
            end
          end else if (rank < cnt_q) begin
            lp_q <= pos_q + 1'b1;
          end else begin
            right_q <= pos_q;
          end
        end
        default: res_ans_q <= '0;
      endcase
    end
    if (cmd_i.mid) begin
      if (lp_q < right_q) begin
        pos_q <= mid;
      end else begin
        res_ans_q <= (lp_q == '0) ? '0 : lp_q - 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      out_ans_q <= res_ans_q;
      out_sts_q <= res_sts_q;
    end
  end

  assign answer_o = out_ans_q;
  assign status_o = out_sts_q;
  assign probe_go = cmd_i.mid && sts_o.search_go;

  `RSB_ASSERT(a_append_step, clk_i, rst_ni, cmd_i.append |=> (loaded_q == $past(loaded_q) + 1'b1))
  `RSB_ASSERT(a_mid_win, clk_i, rst_ni, probe_go |=> (pos_q >= $past(lp_q) && pos_q < $past(right_q)))

endmodule

[rtl/rank_select_bitvector.sv]
// Top level of the rank/select bit vector.
//
//  channel  dir  payload                                            transaction
//  req_i    in   action word_data bit_index target_count bit_value  valid & ready
//  rsp_o    out  answer status                                      valid & ready
//  cfg      in   cfg_wdata_i (bit_length)                           cfg_we_i
//
//  One transaction at a time; a new request is taken the cycle after the previous
//  result enters the output register, even while that result still waits.
//  Clear, unknown actions, append when full, index errors, zero count: EXEC, FIN.
//  Append: EXEC, APND, FIN. Access, rank and select past the total count: EXEC,
//  RD, ONES, EVAL, FIN. Select: EXEC, RD, ONES, EVAL, MID, then at most
//  ceil(log2(bit_length + 1)) probes (memory read, popcount, rank compare, midpoint), FIN.
//  Reset empties the vector and sets bit_length to zero; a stalled response holds.
module rank_select_bitvector (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  rsb_in_if.sink                   req_i,
  rsb_out_if.source                rsp_o,
  input  logic                     cfg_we_i,
  input  logic [rsb_pkg::IdxW-1:0] cfg_wdata_i
);

  rsb_pkg::cmd_t cmd;
  rsb_pkg::sts_t sts;

  rsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (req_i.action),
    .word_data_i    (req_i.word_data),
    .bit_index_i    (req_i.bit_index),
    .target_count_i (req_i.target_count),
    .bit_value_i    (req_i.bit_value),
    .answer_o       (rsp_o.answer),
    .status_o       (rsp_o.status)
  );

endmodule
